@@ rtl/core/lwns_pkg.sv @@
// lwns_pkg: shared types, constants and the reciprocal table of the lambert w solver
// no dependencies; used by lwns_divider, lambert_w_newton_solver, lwns_checker and tb
package lwns_pkg;

  localparam int WORD_W   = 64;
  localparam int FRAC_W   = 32;
  localparam int Y_W      = 38;
  localparam int DEN_W    = 39;
  localparam int TOL_W    = 24;
  localparam int LIMIT_W  = 8;
  localparam int STEPS_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0]      LN2_W   = 32'd2977044472;
  localparam logic [Y_W-1:0]   Y_MAX   = {Y_W{1'b1}};
  localparam logic [8:0]       EXP_SHIFT_MAX = 9'd24;
  localparam logic [7:0]       EXP_ZERO_SHIFT = 8'd40;
  localparam logic [3:0]       LN_TERMS  = 4'd12;
  localparam logic [3:0]       EXP_TERMS = 4'd14;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 24'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

  localparam logic [STATUS_W-1:0] STAT_CONV  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_SGO, ST_SDIV, ST_SQ, ST_SQW,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_LNM, ST_LNF, ST_LOOP,
    ST_EGO, ST_EDIV, ST_ESET, ST_EXPF, ST_NGO, ST_NDIV, ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic              long_run;
    logic [WORD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  // floor(2^32 / d)
  function automatic logic [31:0] recip32(input logic [4:0] d);
    logic [31:0] r;
    case (d)
      5'd2:  r = 32'd2147483648;
      5'd3:  r = 32'd1431655765;
      5'd4:  r = 32'd1073741824;
      5'd5:  r = 32'd858993459;
      5'd6:  r = 32'd715827882;
      5'd7:  r = 32'd613566756;
      5'd8:  r = 32'd536870912;
      5'd9:  r = 32'd477218588;
      5'd10: r = 32'd429496729;
      5'd11: r = 32'd390451572;
      5'd12: r = 32'd357913941;
      5'd13: r = 32'd330382099;
      5'd14: r = 32'd306783378;
      5'd15: r = 32'd286331153;
      5'd16: r = 32'd268435456;
      5'd17: r = 32'd252645135;
      5'd18: r = 32'd238609294;
      5'd19: r = 32'd226050910;
      5'd20: r = 32'd214748364;
      5'd21: r = 32'd204522252;
      5'd22: r = 32'd195225786;
      5'd23: r = 32'd186737708;
      5'd24: r = 32'd178956970;
      5'd25: r = 32'd171798691;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/lwns_divider.sv @@
// lwns_divider: restoring unsigned divider, one quotient bit per cycle
// depends on lwns_pkg (div_req_t, div_rsp_t, widths)
module lwns_divider
  import lwns_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] SHORT_LAST = 7'd63;
  localparam logic [CNT_W-1:0] LONG_LAST  = 7'd95;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] num_r;
  logic [WORD_W-1:0] quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem_r, num_r[WORD_W-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.long_run ? LONG_LAST : SHORT_LAST;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      den_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[WORD_W-2:0], 1'b0};
      rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[WORD_W-2:0], fits};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;

endmodule

@@ rtl/core/lambert_w_newton_solver.sv @@
// lambert_w_newton_solver: principal branch lambert w by newton iteration, fixed point
// depends on lwns_pkg and lwns_divider
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_x_value (Q16.16 by default)
//   out     | output    | out_valid / out_stall| out_w_value, out_status, out_steps_used
//   cfg     | input     | cfg_write_en         | cfg_index, cfg_wdata
//
// a zero argument goes straight to the finish state; otherwise the solver computes ln x
// once and then, per newton step, ln y (skipped while y is zero), exp and a quotient.
// the divider gives one quotient bit a cycle, and each series term steps through states
// T1 to T4 on the one shared 32x32 multiplier.
// reset sets the tolerance to 1 and the limit to 100; there is no clearing pass.
// one item at a time; a finished result sits in the output register until taken.
module lambert_w_newton_solver
  import lwns_pkg::*;
#(
  parameter int INPUT_BITS  = 32,
  parameter int OUTPUT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [INPUT_BITS-1:0]  in_x_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUTPUT_BITS-1:0] out_w_value,
  output logic [STATUS_W-1:0]    out_status,
  output logic [STEPS_W-1:0]     out_steps_used,
  input  logic                   cfg_write_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TOL_W-1:0]       cfg_wdata
);

  localparam int IN_FRAC = INPUT_BITS / 2;
  localparam int OUT_SH  = OUTPUT_BITS - 8 - FRAC_W;

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]   tol_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [WORD_W-1:0]  norm_r;
  logic [5:0]         lz_r;
  logic [2:0]         nc_r;
  logic [5:0]         frac_r;
  logic               caller_y_r;
  logic               mode_exp_r;
  logic [31:0]        s_r, s2_r, t_r, q_r, r_r;
  logic [33:0]        acc_r;
  logic [3:0]         kk_r;
  logic signed [8:0]  kexp_r;
  logic signed [WORD_W-1:0] lnx_r;
  logic [WORD_W-1:0]  e_r;
  logic [Y_W-1:0]     y_r;
  logic [STEPS_W-1:0] i_r;
  logic [STATUS_W-1:0] stat_r;
  logic               zneg_r, nneg_r;
  logic [DEN_W-1:0]   zr_r;
  logic [6:0]         zq_r;
  logic [2:0]         zc_r;
  logic [WORD_W-1:0]  prod_r;
  logic [31:0]        mul_a, mul_b;

  logic               out_valid_r;
  logic [OUTPUT_BITS-1:0] out_w_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [STEPS_W-1:0]     out_steps_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lwns_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // normalizer
  logic [6:0] nshift;
  logic       top_zero;
  assign nshift   = 7'd32 >> nc_r;
  assign top_zero = (norm_r >> (7'd64 - nshift)) == '0;

  // ln combine
  logic [5:0]        p_idx;
  logic signed [7:0] pm;
  logic [7:0]        pm_mag;
  logic signed [WORD_W-1:0] ln_scaled, ln_val, y_wide, res, z_val, n_val, y_next;
  logic [WORD_W-1:0] res_mag, z_mag, n_mag;
  logic              conv;
  logic [Y_W-1:0]    y_init, y_upd;

  assign p_idx  = 6'd63 - lz_r;
  assign pm     = $signed({2'b00, p_idx}) - $signed({2'b00, frac_r});
  assign pm_mag = pm[7] ? 8'(-pm) : 8'(pm);
  assign ln_scaled = pm[7] ? -$signed(prod_r) : $signed(prod_r);
  assign ln_val = ln_scaled + $signed({29'd0, acc_r, 1'b0});
  assign y_wide = $signed({26'd0, y_r});
  assign res    = lnx_r - ln_val - y_wide;
  assign res_mag = res[WORD_W-1] ? WORD_W'(-res) : WORD_W'(res);
  assign conv   = res_mag < {32'd0, tol_r, 8'd0};

  always_comb begin
    if (ln_val > 0) begin
      if (ln_val > $signed({26'd0, Y_MAX})) begin
        y_init = Y_MAX;
      end else begin
        y_init = ln_val[Y_W-1:0];
      end
    end else begin
      y_init = '0;
    end
  end

  // exp range reduction, seven compare and subtract steps
  logic signed [8:0] qk, k_sel;
  logic [31:0]       r_sel;
  logic [DEN_W-1:0]  ln2_sh;
  logic              z_fits;
  assign z_val  = lnx_r - y_wide;
  assign z_mag  = z_val[WORD_W-1] ? WORD_W'(-z_val) : WORD_W'(z_val);
  assign ln2_sh = DEN_W'(LN2_W) << zc_r;
  assign z_fits = zr_r >= ln2_sh;
  assign qk     = $signed({2'b00, zq_r});

  always_comb begin
    if (!zneg_r) begin
      k_sel = qk;
      r_sel = zr_r[31:0];
    end else if (zr_r != '0) begin
      k_sel = -qk - 9'sd1;
      r_sel = LN2_W - zr_r[31:0];
    end else begin
      k_sel = -qk;
      r_sel = '0;
    end
  end

  // exp scaling
  logic [7:0]        nk;
  logic [4:0]        lsh;
  logic [WORD_W-1:0] e_calc;
  assign nk  = 8'(-kexp_r);
  assign lsh = (kexp_r > $signed(EXP_SHIFT_MAX)) ? 5'(EXP_SHIFT_MAX) : kexp_r[4:0];

  always_comb begin
    if (!kexp_r[8]) begin
      e_calc = {30'd0, acc_r} << lsh;
    end else if (nk >= EXP_ZERO_SHIFT) begin
      e_calc = '0;
    end else begin
      e_calc = {30'd0, acc_r} >> nk[5:0];
    end
  end

  // newton update
  assign n_val  = y_wide - $signed(e_r);
  assign n_mag  = n_val[WORD_W-1] ? WORD_W'(-n_val) : WORD_W'(n_val);
  assign y_next = nneg_r ? y_wide + $signed(div_rsp.quotient)
                         : y_wide - $signed(div_rsp.quotient);

  always_comb begin
    if (y_next[WORD_W-1]) begin
      y_upd = '0;
    end else if (y_next > $signed({26'd0, Y_MAX})) begin
      y_upd = Y_MAX;
    end else begin
      y_upd = y_next[Y_W-1:0];
    end
  end

  // series term division by a small divisor
  logic [4:0]  d_small;
  logic [31:0] t_rem, q_fix;
  logic        last_term;
  assign d_small   = mode_exp_r ? {1'b0, kk_r} : {kk_r, 1'b1};
  assign t_rem     = t_r - prod_r[31:0];
  assign q_fix     = q_r + 32'(t_rem >= 32'(d_small));
  assign last_term = mode_exp_r ? (kk_r == EXP_TERMS) : (kk_r == LN_TERMS);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_a     = t_r;
    mul_b     = s2_r;
    div_req   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_x_value == '0) ? ST_FINISH : ST_NORM;
        end
      end
      ST_NORM: begin
        if (nc_r == 3'd5) begin
          state_nxt = ST_SGO;
        end
      end
      ST_SGO: begin
        div_req.start    = 1'b1;
        div_req.long_run = 1'b0;
        div_req.dividend = {norm_r[62:31], 32'd0};
        div_req.divisor  = {5'd0, 2'b10, norm_r[62:31]};
        state_nxt        = ST_SDIV;
      end
      ST_SDIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_a     = s_r;
        mul_b     = s_r;
        state_nxt = ST_SQW;
      end
      ST_SQW: state_nxt = ST_T1;
      ST_T1: begin
        mul_a     = t_r;
        mul_b     = mode_exp_r ? r_r : s2_r;
        state_nxt = ST_T2;
      end
      ST_T2: begin
        mul_a     = prod_r[63:32];
        mul_b     = recip32(d_small);
        state_nxt = ST_T3;
      end
      ST_T3: begin
        mul_a     = prod_r[63:32];
        mul_b     = 32'(d_small);
        state_nxt = ST_T4;
      end
      ST_T4: begin
        if (last_term) begin
          state_nxt = mode_exp_r ? ST_EXPF : ST_LNM;
        end else begin
          state_nxt = ST_T1;
        end
      end
      ST_LNM: begin
        mul_a     = 32'(pm_mag);
        mul_b     = LN2_W;
        state_nxt = ST_LNF;
      end
      ST_LNF: begin
        if (!caller_y_r) begin
          state_nxt = ST_LOOP;
        end else begin
          state_nxt = conv ? ST_FINISH : ST_EGO;
        end
      end
      ST_LOOP: begin
        if (i_r == limit_r) begin
          state_nxt = ST_FINISH;
        end else if (y_r != '0) begin
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_EGO;
        end
      end
      ST_EGO: state_nxt = ST_EDIV;
      ST_EDIV: begin
        if (zc_r == '0) begin
          state_nxt = ST_ESET;
        end
      end
      ST_ESET: state_nxt = ST_T1;
      ST_EXPF: state_nxt = ST_NGO;
      ST_NGO: begin
        div_req.start    = 1'b1;
        div_req.long_run = 1'b1;
        div_req.dividend = n_mag;
        div_req.divisor  = {1'b0, y_r} + {7'd1, 32'd0};
        state_nxt        = ST_NDIV;
      end
      ST_NDIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          i_r        <= '0;
          y_r        <= '0;
          stat_r     <= STAT_ZERO;
          norm_r     <= WORD_W'(in_x_value);
          lz_r       <= '0;
          nc_r       <= '0;
          frac_r     <= 6'(IN_FRAC);
          caller_y_r <= 1'b0;
        end
      end
      ST_NORM: begin
        if (top_zero) begin
          norm_r <= norm_r << nshift;
          lz_r   <= lz_r + 6'(nshift);
        end
        nc_r <= nc_r + 3'd1;
      end
      ST_SDIV: begin
        if (div_rsp.done) begin
          s_r <= div_rsp.quotient[31:0];
        end
      end
      ST_SQW: begin
        s2_r       <= prod_r[63:32];
        t_r        <= s_r;
        acc_r      <= {2'b00, s_r};
        kk_r       <= 4'd1;
        mode_exp_r <= 1'b0;
      end
      ST_T2: t_r <= prod_r[63:32];
      ST_T3: q_r <= prod_r[63:32];
      ST_T4: begin
        acc_r <= acc_r + 34'(q_fix);
        kk_r  <= kk_r + 4'd1;
        if (mode_exp_r) begin
          t_r <= q_fix;
        end
      end
      ST_LNF: begin
        if (!caller_y_r) begin
          lnx_r <= ln_val;
          y_r   <= y_init;
        end else if (conv) begin
          stat_r <= STAT_CONV;
        end
      end
      ST_LOOP: begin
        if (i_r == limit_r) begin
          stat_r <= STAT_LIMIT;
        end else if (y_r != '0) begin
          norm_r     <= WORD_W'(y_r);
          lz_r       <= '0;
          nc_r       <= '0;
          frac_r     <= 6'(FRAC_W);
          caller_y_r <= 1'b1;
        end
      end
      ST_EGO: begin
        zneg_r <= z_val[WORD_W-1];
        zr_r   <= z_mag[DEN_W-1:0];
        zq_r   <= '0;
        zc_r   <= 3'd6;
      end
      ST_EDIV: begin
        if (z_fits) begin
          zr_r <= zr_r - ln2_sh;
        end
        zq_r <= {zq_r[5:0], z_fits};
        zc_r <= zc_r - 3'd1;
      end
      ST_ESET: begin
        kexp_r     <= k_sel;
        r_r        <= r_sel;
        t_r        <= r_sel;
        acc_r      <= {2'b01, 32'd0} + {2'b00, r_sel};
        kk_r       <= 4'd2;
        mode_exp_r <= 1'b1;
      end
      ST_EXPF: e_r <= e_calc;
      ST_NGO: nneg_r <= n_val[WORD_W-1];
      ST_NDIV: begin
        if (div_rsp.done) begin
          y_r <= y_upd;
          i_r <= i_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TOL:   tol_r   <= cfg_wdata;
        CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output scaling, rounded when shifting right
  logic [WORD_W-1:0] w_full;
  generate
    if (OUT_SH >= 0) begin : g_lsh
      assign w_full = {26'd0, y_r} << OUT_SH;
    end else begin : g_rsh
      localparam int RSH = -OUT_SH;
      assign w_full = ({26'd0, y_r} + (64'd1 << (RSH - 1))) >> RSH;
    end
  endgenerate

  logic load_out;
  assign load_out = (state_r == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_w_r      <= w_full[OUTPUT_BITS-1:0];
      out_status_r <= stat_r;
      out_steps_r  <= i_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_w_value    = out_w_r;
  assign out_status     = out_status_r;
  assign out_steps_used = out_steps_r;

endmodule

@@ tb/sv/lwns_checker.sv @@
// lwns_checker: watches the in, out and cfg ports of the lambert w solver, predicts each
// result in fixed point and compares it field by field; depends on lwns_pkg
module lwns_checker
  import lwns_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [31:0]          in_x_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [31:0]          out_w_value,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [STEPS_W-1:0]   out_steps_used,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LN2_L = 64'd2977044472;
  localparam longint ONE_L = 64'd1 << 32;
  localparam longint YMAX_L = (64'd64 << 32) - 1;

  typedef struct packed {
    logic [31:0]         w;
    logic [STATUS_W-1:0] status;
    logic [STEPS_W-1:0]  steps;
  } w_result_t;

  w_result_t w_expected[$];
  logic [TOL_W-1:0]   tol_reg;
  logic [LIMIT_W-1:0] limit_reg;

  function automatic int msb_index(bit [63:0] v);
    int p;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    return p;
  endfunction

  function automatic longint log_w32(bit [63:0] v, int frac);
    int p;
    bit [63:0] mant, f, s, s2, t, acc;
    p = msb_index(v);
    mant = (p >= 32) ? (v >> (p - 32)) : (v << (32 - p));
    f = mant - (64'd1 << 32);
    s = (f << 32) / ((64'd2 << 32) + f);
    s2 = (s * s) >> 32;
    t = s;
    acc = s;
    for (int k = 1; k <= 12; k++) begin
      t = (t * s2) >> 32;
      acc += t / 64'(2 * k + 1);
    end
    return longint'(p - frac) * LN2_L + longint'(2 * acc);
  endfunction

  function automatic longint exp_w32(longint z);
    longint k;
    bit [63:0] r, sum, t, u, q, r0;
    if (z >= 0) begin
      k = z / LN2_L;
      r = 64'(z - k * LN2_L);
    end else begin
      u = 64'(-z);
      q = u / 64'(LN2_L);
      r0 = u % 64'(LN2_L);
      k = -longint'(q);
      if (r0 != 0) begin
        k -= 1;
        r = 64'(LN2_L) - r0;
      end else begin
        r = 0;
      end
    end
    sum = 64'd1 << 32;
    t = sum;
    for (int n = 1; n <= 14; n++) begin
      t = ((t * r) >> 32) / 64'(n);
      sum += t;
    end
    if (k >= 0) begin
      if (k > 24) k = 24;
      return longint'(sum << k);
    end
    if (-k >= 40) return 0;
    return longint'(sum >> (-k));
  endfunction

  function automatic longint quot_w32(longint n, longint d);
    bit neg;
    bit [63:0] mag, ud, q, rem;
    neg = n < 0;
    mag = neg ? 64'(-n) : 64'(n);
    ud = 64'(d);
    q = mag / ud;
    rem = mag % ud;
    for (int b = 0; b < 32; b++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= ud) begin
        rem -= ud;
        q |= 64'd1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic w_result_t solve_w(logic [31:0] x, logic [TOL_W-1:0] tol_cfg,
                                        logic [LIMIT_W-1:0] lim);
    w_result_t rv;
    longint lnx, y, tol, res;
    int i;
    bit [63:0] w;
    if (x == 0) begin
      rv.w = 0;
      rv.status = STAT_ZERO;
      rv.steps = 0;
      return rv;
    end
    lnx = log_w32(64'(x), 16);
    y = (lnx > 0) ? lnx : 0;
    if (y > YMAX_L) y = YMAX_L;
    tol = longint'(tol_cfg) << 8;
    i = 0;
    while (i < int'(lim)) begin
      if (y != 0) begin
        res = lnx - log_w32(64'(y), 32) - y;
        if (res < 0) res = -res;
        if (res < tol) break;
      end
      y -= quot_w32(y - exp_w32(lnx - y), ONE_L + y);
      if (y < 0) y = 0;
      if (y > YMAX_L) y = YMAX_L;
      i++;
    end
    w = (64'(y) + 64'd128) >> 8;
    rv.w = w[31:0];
    rv.status = (i == int'(lim)) ? STAT_LIMIT : STAT_CONV;
    rv.steps = i[7:0];
    return rv;
  endfunction

  always @(posedge clk) begin
    w_result_t e;
    if (!rst_n) begin
      tol_reg <= TOL_RESET;
      limit_reg <= LIMIT_RESET;
      w_expected.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_TOL) tol_reg <= cfg_wdata;
        else if (cfg_index == CFG_LIMIT) limit_reg <= cfg_wdata[LIMIT_W-1:0];
      end
      if (in_valid && !in_stall) w_expected.push_back(solve_w(in_x_value, tol_reg, limit_reg));
      if (out_valid && !out_stall) begin
        if (w_expected.size() == 0) begin
          $display("%0t: unexpected beat w=%h status=%0d steps=%0d", $time,
                   out_w_value, out_status, out_steps_used);
          fail_count <= fail_count + 1;
        end else begin
          e = w_expected.pop_front();
          if (e.w !== out_w_value || e.status !== out_status || e.steps !== out_steps_used) begin
            $display("%0t: mismatch expected w=%h status=%0d steps=%0d, got w=%h status=%0d steps=%0d",
                     $time, e.w, e.status, e.steps, out_w_value, out_status, out_steps_used);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    outstanding <= w_expected.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// tb: stimulus and verdict for lambert_w_newton_solver, with lwns_checker beside it
// depends on lwns_pkg, lambert_w_newton_solver and lwns_checker
module tb;
  import lwns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_x_value = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] out_w_value;
  logic [STATUS_W-1:0] out_status;
  logic [STEPS_W-1:0] out_steps_used;
  logic cfg_write_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [TOL_W-1:0] cfg_wdata = 0;
  int fail_count, outstanding;

  bit calm = 0;
  bit hold_req = 0;
  int hold_len = 0;

  always #5 clk = ~clk;

  lambert_w_newton_solver dut (.*);

  lwns_checker chk (.*);

  always @(negedge clk) begin
    int r;
    bit hold_seen;
    if (hold_req && !hold_seen) begin
      hold_seen = 1;
      out_stall = 1;
      repeat (hold_len) @(negedge clk);
      out_stall = 0;
    end else if (calm) begin
      out_stall = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_stall = 0;
      else if (r < 98) out_stall = 1;
      else begin
        out_stall = 1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  task automatic send_x(logic [31:0] x);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_x_value = x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    @(negedge clk);
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    cfg_write_en = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_write_en = 0;
  endtask

  function automatic logic [31:0] pick_x();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 40) return $urandom;
    if (r < 60) return $urandom_range(1, 32'hFFFF);
    if (r < 80) return $urandom_range(32'h8000, 32'h0010_0000);
    if (r < 90) return 32'd1 << $urandom_range(0, 31);
    return ~(32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic run_phase(logic [TOL_W-1:0] tol, logic [LIMIT_W-1:0] lim, int n,
                           bit quiet);
    drain();
    repeat (5) @(negedge clk);
    write_reg(CFG_TOL, tol);
    write_reg(CFG_LIMIT, lim);
    calm = quiet;
    repeat (n) send_x(pick_x());
  endtask

  logic [31:0] directed_x[] = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h0001_0000,
    32'h0000_8000, 32'h0002_B7E1, 32'h0000_FFFF, 32'h0001_0001, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h0000_0100, 32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0000_4000};

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // reset settings, directed corners
    foreach (directed_x[i]) send_x(directed_x[i]);

    // loosest tolerance with the largest limit
    run_phase({TOL_W{1'b1}}, 8'd255, 40, 0);
    // no steps allowed
    run_phase({TOL_W{1'b1}}, 8'd0, 20, 1);
    // zero tolerance never converges
    run_phase(24'd0, 8'd3, 30, 0);

    // spare indexes are ignored
    drain();
    write_reg(CFG_SPARE_2, 24'($urandom));
    write_reg(CFG_SPARE_3, 24'($urandom));
    write_reg(CFG_TOL, 24'd1);
    write_reg(CFG_LIMIT, 8'd255);
    calm = 0;
    repeat (6) send_x($urandom_range(32'h0001_0000, 32'hFFFF_FFFF));

    run_phase(24'd1, 8'd1, 60, 0);

    for (int ph = 0; ph < 10; ph++) begin
      run_phase((ph % 3 == 0) ? 24'($urandom_range(1, 24'hFFFF_FF)) :
                24'($urandom_range(1, 24'h00_1000)),
                8'($urandom_range(1, 6)), 100, ph == 4);
      if (ph == 2) begin
        hold_len = 3000;
        hold_req = 1;
        repeat (12) send_x(pick_x());
        drain();
        repeat (20) send_x(pick_x());
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lwns_pkg.sv
rtl/core/lwns_divider.sv
rtl/core/lambert_w_newton_solver.sv
tb/sv/lwns_checker.sv
tb/sv/tb.sv
